// ===== src/fisr_pkg.sv =====
// ----------------------------------------------------------------------------
// fisr_pkg
// Shared types, constants and single-precision helper functions for the
// fast inverse square root pipeline.
// ----------------------------------------------------------------------------
package fisr_pkg;

  // Single-precision constants
  localparam logic [31:0] GUESS_MAGIC = 32'h5F37_59DF;
  localparam logic [31:0] FP_HALF     = 32'h3F00_0000;
  localparam logic [31:0] FP_ONE_HALF = 32'h3FC0_0000;
  localparam logic [31:0] CANON_NAN   = 32'h7FC0_0000;

  // Unpacked multiplier operand, mantissa normalized to bit 23
  typedef struct packed {
    logic               sgn;
    logic               nan;
    logic               inf;
    logic               zero;
    logic signed [9:0]  exp;
    logic [23:0]        man;
  } fisr_unp_t;

  // Adder operands after swap and alignment
  typedef struct packed {
    logic        sgn;
    logic        sub;
    logic        nan;
    logic        inf;
    logic        inf_sgn;
    logic [7:0]  exp;
    logic [23:0] ml;
    logic [49:0] ms;
  } fisr_al_t;

  // Adder raw sum with leading-zero count
  typedef struct packed {
    logic        sgn;
    logic        sub;
    logic        nan;
    logic        inf;
    logic        inf_sgn;
    logic [7:0]  exp;
    logic [50:0] sum;
    logic [5:0]  lz;
  } fisr_sum_t;

  // Leading zeros of a 24-bit mantissa
  function automatic logic [4:0] lzc24(input logic [23:0] m);
    logic [4:0] lz;
    lz = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) lz = 5'(23 - i);
    end
    return lz;
  endfunction

  // Leading zeros of a 51-bit sum
  function automatic logic [5:0] lzc51(input logic [50:0] m);
    logic [5:0] lz;
    lz = 6'd0;
    for (int i = 0; i < 51; i++) begin
      if (m[i]) lz = 6'(50 - i);
    end
    return lz;
  endfunction

  // Unpack a single and normalize subnormal mantissas
  function automatic fisr_unp_t fp_unpack(input logic [31:0] w);
    fisr_unp_t  u;
    logic [7:0] e;
    logic [4:0] lz;
    e      = w[30:23];
    u.sgn  = w[31];
    u.nan  = (e == 8'hFF) && (w[22:0] != 23'd0);
    u.inf  = (e == 8'hFF) && (w[22:0] == 23'd0);
    u.zero = (e == 8'h00) && (w[22:0] == 23'd0);
    u.man  = {e != 8'h00, w[22:0]};
    u.exp  = (e == 8'h00) ? 10'sd1 : $signed({2'b00, e});
    lz     = lzc24(u.man);
    u.man  = u.man << lz;
    u.exp  = u.exp - $signed({5'd0, lz});
    return u;
  endfunction

  // Round to nearest even; m48 has its leading one at bit 47,
  // e is the biased exponent of that bit (may be below 1 or above 254)
  function automatic logic [31:0] fp_round(input logic sgn, input logic signed [9:0] e,
                                           input logic [47:0] m48);
    logic [47:0]       mm;
    logic [95:0]       wide;
    logic              lost;
    logic [7:0]        be;
    logic signed [9:0] shs;
    logic [5:0]        sh;
    logic              inc;
    logic [30:0]       body;
    mm   = m48;
    lost = 1'b0;
    be   = 8'd0;
    shs  = 10'sd1 - e;
    sh   = (e < -10'sd48) ? 6'd50 : shs[5:0];
    wide = {m48, 48'd0} >> sh;
    if (e >= 10'sd255) begin
      return {sgn, 8'hFF, 23'd0};
    end
    if (e >= 10'sd1) begin
      be = e[7:0];
    end else begin
      // gradual underflow
      mm   = wide[95:48];
      lost = |wide[47:0];
    end
    inc  = mm[23] & ((|mm[22:0]) | lost | mm[24]);
    body = {be, mm[46:24]} + 31'(inc);
    return {sgn, body};
  endfunction

  // Adder stage one: classify, swap by magnitude, align the smaller operand
  function automatic fisr_al_t fp_add_align(input logic [31:0] a, input logic [31:0] b);
    fisr_al_t    r;
    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  eg;
    logic [7:0]  es;
    logic [7:0]  d;
    logic [5:0]  sh;
    logic [23:0] msm;
    logic [99:0] wide;
    logic        a_nan;
    logic        b_nan;
    logic        a_inf;
    logic        b_inf;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    big   = (a[30:0] >= b[30:0]) ? a : b;
    sml   = (a[30:0] >= b[30:0]) ? b : a;
    eg    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    msm   = {sml[30:23] != 8'd0, sml[22:0]};
    d     = eg - es;
    sh    = (d > 8'd50) ? 6'd50 : d[5:0];
    wide  = {msm, 76'd0} >> sh;
    r.sgn     = big[31];
    r.sub     = a[31] ^ b[31];
    r.nan     = a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
    r.inf     = a_inf | b_inf;
    r.inf_sgn = a_inf ? a[31] : b[31];
    r.exp     = eg;
    r.ml      = {big[30:23] != 8'd0, big[22:0]};
    r.ms      = {wide[99:51], wide[50] | (|wide[49:0])};
    return r;
  endfunction

  // Adder last stage: specials, normalize, round
  function automatic logic [31:0] fp_add_finish(input fisr_sum_t s);
    logic [50:0]       nm;
    logic signed [9:0] e;
    nm = s.sum << s.lz;
    e  = $signed({2'b00, s.exp}) + 10'sd1 - $signed({4'd0, s.lz});
    if (s.nan) return CANON_NAN;
    if (s.inf) return {s.inf_sgn, 8'hFF, 23'd0};
    if (s.sum == 51'd0) return {(s.sub ? 1'b0 : s.sgn), 31'd0};
    return fp_round(s.sgn, e, {nm[50:4], nm[3] | (|nm[2:0])});
  endfunction

endpackage

// ===== src/fisr_fmul.sv =====
// ----------------------------------------------------------------------------
// fisr_fmul
// Three-stage single-precision multiplier, round to nearest even, with a
// sideband word that travels alongside each request.
// ----------------------------------------------------------------------------
module fisr_fmul #(
  parameter int SIDE_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_i,
  input  logic [31:0]       a_i,
  input  logic [31:0]       b_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [31:0]       p_o,
  output logic [SIDE_W-1:0] side_o
);
  import fisr_pkg::*;

  logic              vld1_r, vld2_r, vld3_r;
  fisr_unp_t         ua_r, ub_r;
  logic [SIDE_W-1:0] sd1_r, sd2_r, sd3_r;
  logic              sgn2_r, nan2_r, inf2_r, zero2_r;
  logic signed [9:0] es2_r;
  logic [47:0]       prod2_r;
  logic [31:0]       p3_r;
  logic [31:0]       p_nxt;
  logic signed [9:0] e_n;
  logic [47:0]       m_n;

  // Valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  // Stage 1: unpack and normalize; stage 2: multiply; stage 3: round
  always_ff @(posedge clk) begin
    ua_r    <= fp_unpack(a_i);
    ub_r    <= fp_unpack(b_i);
    sd1_r   <= side_i;
    sgn2_r  <= ua_r.sgn ^ ub_r.sgn;
    nan2_r  <= ua_r.nan | ub_r.nan | (ua_r.inf & ub_r.zero) | (ua_r.zero & ub_r.inf);
    inf2_r  <= ua_r.inf | ub_r.inf;
    zero2_r <= ua_r.zero | ub_r.zero;
    es2_r   <= ua_r.exp + ub_r.exp - 10'sd127;
    prod2_r <= ua_r.man * ub_r.man;
    sd2_r   <= sd1_r;
    p3_r    <= p_nxt;
    sd3_r   <= sd2_r;
  end

  // Normalize the product to bit 47 and resolve specials
  always_comb begin
    e_n = prod2_r[47] ? es2_r + 10'sd1 : es2_r;
    m_n = prod2_r[47] ? prod2_r : {prod2_r[46:0], 1'b0};
    if (nan2_r)       p_nxt = CANON_NAN;
    else if (inf2_r)  p_nxt = {sgn2_r, 8'hFF, 23'd0};
    else if (zero2_r) p_nxt = {sgn2_r, 31'd0};
    else              p_nxt = fp_round(sgn2_r, e_n, m_n);
  end

  assign vld_o  = vld3_r;
  assign p_o    = p3_r;
  assign side_o = sd3_r;

  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n) vld_i |-> ##3 vld_o)
    else $error("fmul: request lost");
  a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n) vld_o |-> $past(vld_i, 3))
    else $error("fmul: result without request");
  a_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_o && p_o[30:23] == 8'hFF && p_o[22:0] != 23'd0) |-> p_o[30:0] == CANON_NAN[30:0])
    else $error("fmul: non-canonical NaN");

endmodule

// ===== src/fast_inverse_sqrt_single_unit.sv =====
// ----------------------------------------------------------------------------
// fast_inverse_sqrt_single_unit
// Fast inverse square root of an IEEE-754 single, integer first guess and
// one Newton step, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive in_operand_bits and raise start; the request is
//   taken at each rising edge with start high and busy low. busy is always
//   low, so a new request may be issued every cycle.
//   Result channel: out_valid is high for exactly one cycle with
//   out_estimate_bits for each request taken.
//   Results leave in request order, one per request.
//   The datapath is the chain of four three-stage multipliers and the
//   three-stage adder (plus one input and one output register); throughput
//   is one request per cycle.
//   The receiver cannot stall the unit; it must take every result.
//   Reset (synchronous, rst_n low) clears all valid bits; requests in flight
//   are dropped.
//   Any NaN result is returned as 0x7FC00000.
// ----------------------------------------------------------------------------
module fast_inverse_sqrt_single_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_operand_bits,
  output logic        out_valid,
  output logic [31:0] out_estimate_bits
);
  import fisr_pkg::*;

  logic        g_vld_r;
  logic [31:0] x_r, y_r;
  logic        m1_vld, m2_vld, m3_vld, m4_vld;
  logic [31:0] m1_p, m2_p, m3_p, m4_p;
  logic [31:0] m1_sd, m2_sd, m3_sd;
  logic        a1_vld_r, a2_vld_r, a3_vld_r;
  fisr_al_t    a1_r;
  fisr_sum_t   a2_r;
  logic [31:0] a3_r, ya1_r, ya2_r, ya3_r;
  logic [50:0] sum_n;
  logic        out_valid_r;
  logic [31:0] out_bits_r;
  logic [31:0] out_bits_nxt;

  assign busy = 1'b0;

  // Input register with integer first guess
  always_ff @(posedge clk) begin
    if (!rst_n) g_vld_r <= 1'b0;
    else        g_vld_r <= start;
  end
  always_ff @(posedge clk) begin
    x_r <= in_operand_bits;
    y_r <= GUESS_MAGIC - {in_operand_bits[31], in_operand_bits[31:1]};
  end

  // half = x * 0.5
  fisr_fmul #(.SIDE_W(32)) u_mul_half (
    .clk, .rst_n, .vld_i(g_vld_r), .a_i(x_r), .b_i(FP_HALF), .side_i(y_r),
    .vld_o(m1_vld), .p_o(m1_p), .side_o(m1_sd));

  // t = half * y
  fisr_fmul #(.SIDE_W(32)) u_mul_hy (
    .clk, .rst_n, .vld_i(m1_vld), .a_i(m1_p), .b_i(m1_sd), .side_i(m1_sd),
    .vld_o(m2_vld), .p_o(m2_p), .side_o(m2_sd));

  // t = t * y
  fisr_fmul #(.SIDE_W(32)) u_mul_ty (
    .clk, .rst_n, .vld_i(m2_vld), .a_i(m2_p), .b_i(m2_sd), .side_i(m2_sd),
    .vld_o(m3_vld), .p_o(m3_p), .side_o(m3_sd));

  // s = 1.5 - t: align, add, normalize and round
  assign sum_n = a1_r.sub ? ({1'b0, a1_r.ml, 26'd0} - {1'b0, a1_r.ms})
                          : ({1'b0, a1_r.ml, 26'd0} + {1'b0, a1_r.ms});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_vld_r <= 1'b0;
      a2_vld_r <= 1'b0;
      a3_vld_r <= 1'b0;
    end else begin
      a1_vld_r <= m3_vld;
      a2_vld_r <= a1_vld_r;
      a3_vld_r <= a2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a1_r         <= fp_add_align(FP_ONE_HALF, {~m3_p[31], m3_p[30:0]});
    ya1_r        <= m3_sd;
    a2_r.sgn     <= a1_r.sgn;
    a2_r.sub     <= a1_r.sub;
    a2_r.nan     <= a1_r.nan;
    a2_r.inf     <= a1_r.inf;
    a2_r.inf_sgn <= a1_r.inf_sgn;
    a2_r.exp     <= a1_r.exp;
    a2_r.sum     <= sum_n;
    a2_r.lz      <= lzc51(sum_n);
    ya2_r        <= ya1_r;
    a3_r         <= fp_add_finish(a2_r);
    ya3_r        <= ya2_r;
  end

  // y = y * s
  fisr_fmul #(.SIDE_W(32)) u_mul_ys (
    .clk, .rst_n, .vld_i(a3_vld_r), .a_i(a3_r), .b_i(ya3_r), .side_i(32'd0),
    .vld_o(m4_vld), .p_o(m4_p), .side_o());

  // Output register, NaN canonicalized
  assign out_bits_nxt = ((m4_p[30:23] == 8'hFF) && (m4_p[22:0] != 23'd0)) ? CANON_NAN : m4_p;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= m4_vld;
  end
  always_ff @(posedge clk) begin
    out_bits_r <= out_bits_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_estimate_bits = out_bits_r;

  a_req_to_res: assert property (@(posedge clk) disable iff (!rst_n) start |-> ##17 out_valid)
    else $error("request did not produce a result");
  a_res_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 17))
    else $error("result without request");
  a_add_follows_mul: assert property (@(posedge clk) disable iff (!rst_n)
    a3_vld_r |-> $past(m3_vld, 3))
    else $error("adder stage out of step with multiplier chain");

endmodule

// ===== verif/fast_inverse_sqrt_single_unit_tb.sv =====
// ----------------------------------------------------------------------------
// fast_inverse_sqrt_single_unit_tb
// Self-checking bench for the fast inverse square root unit. A bit-exact
// single-precision predictor (integer guess plus one Newton step, each
// operation rounded to nearest even) scores every result against requests
// sent with random start gaps.
// ----------------------------------------------------------------------------
module fast_inverse_sqrt_single_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fisr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 24;

  // Scoreboard: predicts estimates and checks them in order
  class rsqrt_scoreboard;
    logic [31:0] estimate_q[$];
    int          n_req;
    int          n_res;
    int          n_err;

    // Right shift keeping the lost bits as a sticky lsb
    function logic [63:0] shr_sticky(logic [63:0] m, int n);
      logic [63:0] r;
      if (n <= 0) return m;
      if (n >= 64) return {63'd0, |m};
      r = m >> n;
      r[0] = r[0] | (|(m & ((64'd1 << n) - 64'd1)));
      return r;
    endfunction

    // Round and pack; value = m / 2^63 * 2^(e - 127), m nonzero
    function logic [31:0] round_pack(logic s, int e, logic [63:0] m);
      logic        inc;
      logic [30:0] body;
      while (!m[63]) begin
        m = m << 1;
        e = e - 1;
      end
      if (e >= 255) return {s, 8'hFF, 23'd0};
      if (e < 1) begin
        m = shr_sticky(m, 1 - e);
        e = 0;
      end
      inc  = m[39] & ((|m[38:0]) | m[40]);
      body = {e[7:0], m[62:40]} + 31'(inc);
      return {s, body};
    endfunction

    function logic is_nan(logic [31:0] w);
      return (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
    endfunction

    function logic is_inf(logic [31:0] w);
      return (w[30:23] == 8'hFF) && (w[22:0] == 23'd0);
    endfunction

    function int exp_of(logic [31:0] w);
      return (w[30:23] == 8'd0) ? 1 : int'(w[30:23]);
    endfunction

    function logic [63:0] man_of(logic [31:0] w);
      return {40'd0, w[30:23] != 8'd0, w[22:0]};
    endfunction

    function logic [31:0] sp_mul(logic [31:0] a, logic [31:0] b);
      logic s;
      s = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return CANON_NAN;
      if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0))
        return CANON_NAN;
      if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {s, 31'd0};
      return round_pack(s, exp_of(a) + exp_of(b) - 126,
                        (man_of(a) * man_of(b)) << 16);
    endfunction

    function logic [31:0] sp_sub(logic [31:0] a, logic [31:0] b);
      logic [63:0] ma;
      logic [63:0] mb;
      logic [63:0] r;
      int          ea;
      int          eb;
      logic        sa;
      logic        sb;
      sa = a[31];
      sb = ~b[31];
      if (is_nan(a) || is_nan(b)) return CANON_NAN;
      if (is_inf(a) && is_inf(b)) return (sa == sb) ? {sa, 8'hFF, 23'd0} : CANON_NAN;
      if (is_inf(a)) return a;
      if (is_inf(b)) return {sb, 8'hFF, 23'd0};
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {sa & sb, 31'd0};
      if (b[30:0] == 31'd0) return a;
      if (a[30:0] == 31'd0) return {sb, b[30:0]};
      ea = exp_of(a);
      eb = exp_of(b);
      ma = man_of(a) << 39;
      mb = man_of(b) << 39;
      if (ea >= eb) mb = shr_sticky(mb, ea - eb);
      else ma = shr_sticky(ma, eb - ea);
      if (eb > ea) ea = eb;
      if (sa == sb) return round_pack(sa, ea + 1, ma + mb);
      if (ma == mb) return 32'd0;
      if (ma > mb) return round_pack(sa, ea + 1, ma - mb);
      return round_pack(sb, ea + 1, mb - ma);
    endfunction

    // Integer guess followed by one Newton step
    function logic [31:0] rsqrt_estimate(logic [31:0] x);
      logic [31:0] y;
      logic [31:0] t;
      y = GUESS_MAGIC - {x[31], x[31:1]};
      t = sp_mul(x, FP_HALF);
      t = sp_mul(t, y);
      t = sp_mul(t, y);
      t = sp_sub(FP_ONE_HALF, t);
      y = sp_mul(y, t);
      return is_nan(y) ? CANON_NAN : y;
    endfunction

    function void note_request(logic [31:0] x);
      estimate_q.push_back(rsqrt_estimate(x));
      n_req++;
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] exp_val;
      n_res++;
      if (estimate_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        n_err++;
        return;
      end
      exp_val = estimate_q.pop_front();
      if (got !== exp_val) begin
        $display("%0t: estimate mismatch expected %h actual %h", $time, exp_val, got);
        n_err++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_operand_bits;
  logic        out_valid;
  logic [31:0] out_estimate_bits;

  rsqrt_scoreboard sb = new();
  int              cycle_cnt = 0;

  fast_inverse_sqrt_single_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operand_bits  (in_operand_bits),
    .out_valid        (out_valid),
    .out_estimate_bits(out_estimate_bits)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_estimate_bits);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Issue one request, hold until taken
  task automatic send_request(logic [31:0] x);
    @(negedge clk);
    start           <= 1'b1;
    in_operand_bits <= x;
    do @(posedge clk); while (busy);
    sb.note_request(x);
  endtask

  task automatic idle_cycles(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  function automatic logic [31:0] random_operand();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 5))
      0: ;                                             // any pattern
      1: w[30:23] = 8'($urandom_range(100, 154));      // everyday magnitudes
      2: w[30:23] = 8'($urandom_range(0, 3));          // subnormal edge
      3: w[30:23] = 8'($urandom_range(250, 255));      // huge, inf, NaN
      4: w = {1'b0, 8'($urandom_range(1, 254)), w[22:0]};
      default: w[30:23] = 8'($urandom_range(60, 200));
    endcase
    return w;
  endfunction

  logic [31:0] corner_vals[] = '{
    32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h0000_0002, 32'h007F_FFFF,
    32'h0080_0000, 32'h7F7F_FFFF, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
    32'h7F80_0001, 32'hFFFF_FFFF, 32'h3F80_0000, 32'h4080_0000, 32'hBF80_0000,
    32'h3E80_0000, 32'h5F37_59DF, 32'h0000_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};

  initial begin
    int n_rand;
    int drain;
    n_rand          = 550;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_operand_bits = 32'd0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed corners, back to back
    foreach (corner_vals[i]) send_request(corner_vals[i]);

    // Random requests; last stretch runs without gaps
    for (int i = 0; i < n_rand; i++) begin
      send_request(random_operand());
      if (i < n_rand - 100 && $urandom_range(0, 3) == 0)
        idle_cycles($urandom_range(1, 18));
    end
    @(negedge clk);
    start <= 1'b0;

    drain = 0;
    while (sb.estimate_q.size() != 0) @(posedge clk);
    while (drain < DRAIN_CYCLES) begin
      @(posedge clk);
      drain++;
    end

    $display("Sent %0d requests (corner values and random words), checked %0d estimates",
             sb.n_req, sb.n_res);
    if (sb.n_err == 0 && sb.estimate_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
